### design/arlc_pkg.sv
`default_nettype none

package arlc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OUT_W   = 31;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned WGT_W   = 33;
  localparam int unsigned PROD_W  = DATA_W + WGT_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned TDATA_W = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] a;
  } vec_t;

  typedef struct packed {
    logic adv;  // pipeline advances this cycle
    logic act;  // layer is applied
  } lyr_ctrl_t;

  // weight or bias in hundredths, rounded to nearest, halves up
  function automatic longint hundredths_to_fixed(input int unsigned h,
                                                 input int unsigned fb);
    longint scaled;
    scaled = longint'(h) << fb;
    return (scaled + 64'sd50) / 64'sd100;
  endfunction

endpackage

`default_nettype wire

### design/arlc_layer.sv
`default_nettype none

module arlc_layer #(
  parameter int unsigned LAYER_IDX = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  arlc_pkg::lyr_ctrl_t   ctrl_i,
  input  wire                   valid_i,
  input  arlc_pkg::vec_t        vec_i,
  output logic                  valid_o,
  output arlc_pkg::vec_t        vec_o
);
  import arlc_pkg::*;

  localparam logic signed [WGT_W-1:0] W00 =
    WGT_W'(hundredths_to_fixed(50 + LAYER_IDX, FRAC_BITS));
  localparam logic signed [WGT_W-1:0] W01 = WGT_W'(hundredths_to_fixed(10, FRAC_BITS));
  localparam logic signed [WGT_W-1:0] W10 = WGT_W'(hundredths_to_fixed(15, FRAC_BITS));
  localparam logic signed [WGT_W-1:0] W11 =
    WGT_W'(hundredths_to_fixed(55 + LAYER_IDX, FRAC_BITS));
  localparam logic signed [SUM_W-1:0] B0 =
    SUM_W'(hundredths_to_fixed(2 * LAYER_IDX, FRAC_BITS));
  localparam logic signed [SUM_W-1:0] B1 =
    SUM_W'(hundredths_to_fixed(LAYER_IDX, FRAC_BITS));
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);

  logic                     valid1_q;
  logic signed [PROD_W-1:0] p00_q, p01_q, p10_q, p11_q;
  vec_t                     vec1_q;
  logic                     valid2_q;
  vec_t                     vec2_q, vec2_d;
  logic signed [SUM_W-1:0]  sum0, sum1;

  // stage 1: products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      p00_q  <= W00 * $signed(vec_i.a);
      p01_q  <= W01 * $signed(vec_i.b);
      p10_q  <= W10 * $signed(vec_i.a);
      p11_q  <= W11 * $signed(vec_i.b);
      vec1_q <= vec_i;
    end
  end

  // stage 2: floor shift, sum, saturate, ReLU, or pass the input through when not applied
  function automatic logic signed [DATA_W-1:0] sat_relu(input logic signed [SUM_W-1:0] s);
    logic signed [DATA_W-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    sum0 = SUM_W'(p00_q >>> FRAC_BITS) + SUM_W'(p01_q >>> FRAC_BITS) + B0;
    sum1 = SUM_W'(p10_q >>> FRAC_BITS) + SUM_W'(p11_q >>> FRAC_BITS) + B1;
    if (ctrl_i.act) begin
      vec2_d.a = sat_relu(sum0);
      vec2_d.b = sat_relu(sum1);
    end else begin
      vec2_d = vec1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      vec2_q <= vec2_d;
    end
  end

  assign valid_o = valid2_q;
  assign vec_o   = vec2_q;

endmodule

`default_nettype wire

### design/affine_relu_layer_chain_top.sv
// Throughput: one vector per cycle; each layer is a multiply stage and a
// sum/saturate/ReLU stage, and the whole chain stalls together on output backpressure.
// Reset: asynchronous, active low; clears all valid bits and sets device_count to 1.
`default_nettype none

module affine_relu_layer_chain_top #(
  parameter int unsigned LAYER_COUNT = 8,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] vec_in_a, [63:32] vec_in_b
  input  wire  [arlc_pkg::TDATA_W-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [30:0] vec_out_a, [61:31] vec_out_b, [63:62] zero
  output logic [arlc_pkg::TDATA_W-1:0]     m_axis_tdata,
  input  wire                              cfg_we_i,
  input  wire  [arlc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import arlc_pkg::*;

  localparam int unsigned NL_W = $clog2(LAYER_COUNT + 1);

  logic [NL_W-1:0] layers_q, layers_d;
  logic            adv;
  logic            valid_vec [LAYER_COUNT+1];
  vec_t            data_vec  [LAYER_COUNT+1];
  logic [LAYER_COUNT-1:0] lyr_valid;
  vec_t            vout;

  // layers applied: largest multiple of device_count (0 read as 1) not above LAYER_COUNT
  always_comb begin
    logic [CFG_W-1:0] dc;
    dc = (cfg_wdata_i == '0) ? CFG_W'(1) : cfg_wdata_i;
    layers_d = '0;
    for (int k = 1; k <= LAYER_COUNT; k++) begin
      if (k * int'(dc) <= LAYER_COUNT) begin
        layers_d = NL_W'(k * int'(dc));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layers_q <= NL_W'(LAYER_COUNT);
    end else if (cfg_we_i) begin
      layers_q <= layers_d;
    end
  end

  assign adv           = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv;

  assign valid_vec[0]  = s_axis_tvalid;
  assign data_vec[0]   = vec_t'(s_axis_tdata);

  for (genvar l = 0; l < LAYER_COUNT; l++) begin : g_layer
    lyr_ctrl_t ctrl;
    assign ctrl.adv = adv;
    assign ctrl.act = (NL_W'(l) < layers_q);

    arlc_layer #(
      .LAYER_IDX (l),
      .FRAC_BITS (FRAC_BITS)
    ) u_layer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .valid_i (valid_vec[l]),
      .vec_i   (data_vec[l]),
      .valid_o (valid_vec[l+1]),
      .vec_o   (data_vec[l+1])
    );

    assign lyr_valid[l] = valid_vec[l+1];
  end

  assign vout          = data_vec[LAYER_COUNT];
  assign m_axis_tvalid = valid_vec[LAYER_COUNT];

  // final clamp to [0, 2^31-1]
  always_comb begin
    logic [OUT_W-1:0] oa, ob;
    oa = vout.a[DATA_W-1] ? '0 : vout.a[OUT_W-1:0];
    ob = vout.b[DATA_W-1] ? '0 : vout.b[OUT_W-1:0];
    m_axis_tdata = {(TDATA_W - 2*OUT_W)'(0), ob, oa};
  end

  a_layers_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(layers_q) <= LAYER_COUNT)
    else $error("layer count out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(lyr_valid))
    else $error("pipeline valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> g_layer[0].u_layer.valid1_q)
    else $error("accepted transfer did not enter the pipeline");

endmodule

`default_nettype wire

### tb/tb_affine_relu_layer_chain_top.sv
`default_nettype none

module tb_affine_relu_layer_chain_top;

  localparam int unsigned LAYERS   = 8;
  localparam int unsigned FRAC     = 16;
  localparam int unsigned SETTLE   = 2 * LAYERS + 4;
  localparam int unsigned HOLD_CYC = 80;
  localparam int unsigned N_PHASE  = 15;
  localparam int unsigned PHASE_N  = 55;
  localparam int unsigned N_DIR    = 21;

  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [30:0] U_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [30:0] b;
    logic [30:0] a;
  } chain_out_t;

  typedef struct packed {
    logic [3:0]  dc;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    logic [30:0] ea;
    logic [30:0] eb;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{4'd1,  32'h0000_0000, 32'h0000_0000, 1'b0, 31'h0, 31'h0},
    '{4'd1,  S_MAX,         S_MAX,         1'b0, 31'h0, 31'h0},
    '{4'd1,  S_MIN,         S_MIN,         1'b0, 31'h0, 31'h0},
    '{4'd1,  S_MAX,         S_MIN,         1'b0, 31'h0, 31'h0},
    '{4'd1,  S_MIN,         S_MAX,         1'b0, 31'h0, 31'h0},
    '{4'd1,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 31'h0, 31'h0},
    '{4'd1,  32'h0001_0000, 32'h0000_8000, 1'b0, 31'h0, 31'h0},
    '{4'd0,  32'h0001_0000, 32'h0002_0000, 1'b0, 31'h0, 31'h0},
    '{4'd0,  S_MAX,         32'h0000_0000, 1'b0, 31'h0, 31'h0},
    '{4'd2,  32'h0003_0000, 32'hFFFF_0000, 1'b0, 31'h0, 31'h0},
    '{4'd3,  32'h0005_0000, 32'h0005_0000, 1'b0, 31'h0, 31'h0},
    '{4'd5,  32'h7FFF_0000, 32'h0000_0001, 1'b0, 31'h0, 31'h0},
    '{4'd7,  32'h0000_0001, 32'h7FFF_0000, 1'b0, 31'h0, 31'h0},
    '{4'd8,  S_MAX,         S_MAX,         1'b0, 31'h0, 31'h0},
    // more partitions than layers: input passes through, clamped
    '{4'd9,  32'h0000_0000, 32'h0000_0000, 1'b1, 31'h0, 31'h0},
    '{4'd9,  S_MAX,         S_MIN,         1'b1, U_MAX, 31'h0},
    '{4'd9,  S_MIN,         S_MAX,         1'b1, 31'h0, U_MAX},
    '{4'd9,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 31'h0, 31'h0},
    '{4'd9,  32'h1234_5678, 32'h5EDC_BA98, 1'b1, 31'h1234_5678, 31'h5EDC_BA98},
    '{4'd15, S_MAX,         S_MAX,         1'b1, U_MAX, U_MAX},
    '{4'd15, 32'h0000_0001, 32'h8000_0001, 1'b1, 31'h1, 31'h0}
  };

  localparam logic [3:0] PHASE_DC [N_PHASE] = '{
    4'd2, 4'd4, 4'd1, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8,
    4'd0, 4'd9, 4'd12, 4'd15, 4'd1, 4'd8, 4'd3
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [arlc_pkg::TDATA_W-1:0]   s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [arlc_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                           cfg_we_i;
  logic [arlc_pkg::CFG_W-1:0]     cfg_wdata_i;

  chain_out_t  out_exp_q [$];
  chain_out_t  want_out;
  chain_out_t  got_out;
  chain_out_t  row_exp;
  logic        row_typed;
  logic [3:0]  dc_model;
  logic [3:0]  dc_cur;
  bit          no_idle;
  bit          hold_req;
  int unsigned errors;

  affine_relu_layer_chain_top #(
    .LAYER_COUNT(LAYERS),
    .FRAC_BITS  (FRAC)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic longint q_hundredths(input int unsigned h);
    return ((longint'(h) << FRAC) + 64'sd50) / 64'sd100;
  endfunction

  function automatic longint q_mul(input longint w, input longint x);
    return (w * x) >>> FRAC;
  endfunction

  function automatic longint sat_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic chain_out_t predict_chain(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [3:0] dc);
    longint      x0;
    longint      x1;
    longint      s0;
    longint      s1;
    int unsigned d;
    int unsigned n;
    chain_out_t  o;
    x0 = longint'(a);
    x1 = longint'(b);
    d = (dc == 4'd0) ? 1 : int'(dc);
    n = (LAYERS / d) * d;
    for (int unsigned l = 0; l < n; l++) begin
      s0 = sat_s32(q_mul(q_hundredths(50 + l), x0) + q_mul(q_hundredths(10), x1)
                   + q_hundredths(2 * l));
      s1 = sat_s32(q_mul(q_hundredths(15), x0) + q_mul(q_hundredths(55 + l), x1)
                   + q_hundredths(l));
      x0 = (s0 > 0) ? s0 : 0;
      x1 = (s1 > 0) ? s1 : 0;
    end
    o.a = (x0 > 0) ? x0[30:0] : '0;
    o.b = (x1 > 0) ? x1[30:0] : '0;
    return o;
  endfunction

  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = 32'($urandom_range(32'h3FFFF)) - 32'h20000;
      6:          v = {1'b0, 31'($urandom)};
      7: begin
        case ($urandom_range(4))
          0:       v = S_MAX;
          1:       v = S_MIN;
          2:       v = 32'h0;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h1;
        endcase
      end
      default:    v = 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  task automatic push_vec(input logic [31:0] a, input logic [31:0] b);
    arlc_pkg::vec_t v;
    v.a = a;
    v.b = b;
    while (!no_idle && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (out_exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_dc(input logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // transfer monitor: predicts on input, checks on output
  always @(posedge clk_i) begin
    if (cfg_we_i)
      dc_model = cfg_wdata_i;
    if (s_axis_tvalid && s_axis_tready) begin
      if (row_typed)
        out_exp_q.push_back(row_exp);
      else
        out_exp_q.push_back(predict_chain(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                          dc_model));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got_out.a = m_axis_tdata[30:0];
      got_out.b = m_axis_tdata[61:31];
      if (out_exp_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata, 64'h0);
      end else begin
        want_out = out_exp_q.pop_front();
        if (got_out.a !== want_out.a)
          report_mismatch("vec_out_a", 64'(got_out.a), 64'(want_out.a));
        if (got_out.b !== want_out.b)
          report_mismatch("vec_out_b", 64'(got_out.b), 64'(want_out.b));
        if (m_axis_tdata[63:62] !== 2'b00)
          report_mismatch("pad bits", 64'(m_axis_tdata[63:62]), 64'h0);
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    row_typed     = 1'b0;
    row_exp       = '0;
    dc_model      = 4'd1;
    dc_cur        = 4'd1;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    errors        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows; first group runs on the reset value of device_count
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_TAB[r].dc != dc_cur) begin
        wait_drained();
        write_dc(DIR_TAB[r].dc);
        dc_cur = DIR_TAB[r].dc;
      end
      row_typed = DIR_TAB[r].typed;
      row_exp.a = DIR_TAB[r].ea;
      row_exp.b = DIR_TAB[r].eb;
      push_vec(DIR_TAB[r].a, DIR_TAB[r].b);
    end
    row_typed = 1'b0;

    for (int p = 0; p < N_PHASE; p++) begin
      wait_drained();
      write_dc(PHASE_DC[p]);
      no_idle = (p == 7);
      for (int i = 0; i < PHASE_N; i++) begin
        if (p == 3 && i == 10)
          hold_req = 1'b1;
        if (p == 6 && i == 25)
          wait_drained();
        push_vec(rand_elem(), rand_elem());
      end
      no_idle = 1'b0;
    end

    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
